// ----- design/des_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_pkg
// shared constants, types and the record comparator of the directory sorter
// ----------------------------------------------------------------------------
package des_pkg;

    localparam int ENTRIES   = 112;
    localparam int KEY_BYTES = 13;
    localparam int WORD_W    = 64;
    localparam int REC_W     = 4 * WORD_W;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int SLOT_W    = 7;

    localparam logic       CMD_LOAD       = 1'b0;
    localparam logic       CMD_READ       = 1'b1;
    localparam logic       STATUS_OK      = 1'b0;
    localparam logic       STATUS_REFUSED = 1'b1;
    localparam logic [7:0] BYTE_FREE      = 8'h00;
    localparam logic [7:0] BYTE_DELETED   = 8'hff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_SORT_RD_I,
        ST_SORT_GET_I,
        ST_SORT_RD_J,
        ST_SORT_CMP,
        ST_SORT_WB_I
    } des_state_t;

    typedef struct packed {
        logic load_wr;
        logic sort_start;
        logic rd_rec;
        logic out_rec;
        logic out_refuse;
        logic rd_i;
        logic get_i;
        logic rd_j;
        logic cmp;
        logic wb_i;
    } des_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic load_last;
        logic read_last;
        logic i_last;
        logic j_last;
    } des_stat_t;

    // true when the earlier record a must trade places with the later record b
    function automatic logic must_swap(input logic [REC_W-1:0] a,
                                       input logic [REC_W-1:0] b,
                                       input logic desc);
        logic [7:0]       a0;
        logic [7:0]       b0;
        logic             a_used;
        logic             b_used;
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        logic             res;
        a0     = a[REC_W-1 -: 8];
        b0     = b[REC_W-1 -: 8];
        a_used = (a0 != BYTE_FREE) && (a0 != BYTE_DELETED);
        b_used = (b0 != BYTE_FREE) && (b0 != BYTE_DELETED);
        ka     = a[REC_W-1 -: KEY_W];
        kb     = b[REC_W-1 -: KEY_W];
        res    = 1'b0;
        if (a0 == BYTE_FREE && b0 == BYTE_DELETED)
        begin
            res = 1'b1;
        end
        else if (!a_used && b_used)
        begin
            res = 1'b1;
        end
        else if (a_used && b_used)
        begin
            res = desc ? (ka < kb) : (ka > kb);
        end
        return res;
    endfunction

endpackage

// ----- design/des_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_if
// valid/ready channels of the directory sorter: request, response, config
// ----------------------------------------------------------------------------
interface des_req_if;
    import des_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] word2;
    logic [WORD_W-1:0] word3;

    modport source (output valid, cmd, word0, word1, word2, word3, input ready);
    modport sink   (input valid, cmd, word0, word1, word2, word3, output ready);
endinterface

interface des_rsp_if;
    import des_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word0;
    logic [WORD_W-1:0] out_word1;
    logic [WORD_W-1:0] out_word2;
    logic [WORD_W-1:0] out_word3;
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic              status;

    modport source (output valid, out_word0, out_word1, out_word2, out_word3,
                    slot, last, status, input ready);
    modport sink   (input valid, out_word0, out_word1, out_word2, out_word3,
                    slot, last, status, output ready);
endinterface

interface des_cfg_if;
    logic valid;
    logic ready;
    logic descending;

    modport source (output valid, descending, input ready);
    modport sink   (input valid, descending, output ready);
endinterface

// ----- design/des_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module des_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ----- design/des_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_ctrl
// sequencer for load, read-out and the exchange sort of the directory table
// ----------------------------------------------------------------------------
module des_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_cmd,
    output logic               in_ready,
    input  des_pkg::des_stat_t stat,
    output des_pkg::des_cmd_t  cmd
);
    import des_pkg::*;

    des_state_t state_reg;
    des_state_t state_next;
    logic       sorted_reg;
    logic       sorted_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sorted_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sorted_reg <= sorted_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sorted_next = sorted_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !stat.out_busy;
                if (in_valid && !stat.out_busy)
                begin
                    if (in_cmd == CMD_LOAD)
                    begin
                        if (!sorted_reg)
                        begin
                            cmd.load_wr = 1'b1;
                            if (stat.load_last)
                            begin
                                cmd.sort_start = 1'b1;
                                state_next     = ST_SORT_RD_I;
                            end
                        end
                    end
                    else if (sorted_reg)
                    begin
                        cmd.rd_rec = 1'b1;
                        state_next = ST_READ_WAIT;
                    end
                    else
                    begin
                        cmd.out_refuse = 1'b1;
                    end
                end
            end
            ST_READ_WAIT:
            begin
                cmd.out_rec = 1'b1;
                if (stat.read_last)
                begin
                    sorted_next = 1'b0;
                end
                state_next = ST_IDLE;
            end
            ST_SORT_RD_I:
            begin
                cmd.rd_i   = 1'b1;
                state_next = ST_SORT_GET_I;
            end
            ST_SORT_GET_I:
            begin
                cmd.get_i  = 1'b1;
                state_next = ST_SORT_RD_J;
            end
            ST_SORT_RD_J:
            begin
                cmd.rd_j   = 1'b1;
                state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = stat.j_last ? ST_SORT_WB_I : ST_SORT_RD_J;
            end
            ST_SORT_WB_I:
            begin
                cmd.wb_i = 1'b1;
                if (stat.i_last)
                begin
                    sorted_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SORT_RD_I;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/des_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_dp
// record store, sort indices, held record, comparator and output register
// ----------------------------------------------------------------------------
module des_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [des_pkg::WORD_W-1:0] word0,
    input  logic [des_pkg::WORD_W-1:0] word1,
    input  logic [des_pkg::WORD_W-1:0] word2,
    input  logic [des_pkg::WORD_W-1:0] word3,
    input  logic                      cfg_valid,
    input  logic                      cfg_descending,
    input  des_pkg::des_cmd_t         cmd,
    output des_pkg::des_stat_t        stat,
    des_rsp_if.source                 rsp
);
    import des_pkg::*;

    logic [IDX_W-1:0] load_cnt_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [REC_W-1:0] cur_reg;
    logic             desc_reg;
    logic             sort_desc_reg;
    logic             out_valid_reg;
    logic [REC_W-1:0] out_rec_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic             out_last_reg;
    logic             out_status_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [REC_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [REC_W-1:0] ram_rdata;
    logic             swap;

    assign swap = must_swap(cur_reg, ram_rdata, sort_desc_reg);

    assign stat.out_busy  = out_valid_reg;
    assign stat.load_last = (load_cnt_reg == IDX_W'(ENTRIES - 1));
    assign stat.read_last = (rd_ptr_reg == IDX_W'(ENTRIES - 1));
    assign stat.i_last    = (i_reg == IDX_W'(ENTRIES - 2));
    assign stat.j_last    = (j_reg == IDX_W'(ENTRIES - 1));

    // store port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = load_cnt_reg;
        ram_wdata = {word0, word1, word2, word3};
        if (cmd.load_wr)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.cmp && swap)
        begin
            ram_we    = 1'b1;
            ram_waddr = j_reg;
            ram_wdata = cur_reg;
        end
        else if (cmd.wb_i)
        begin
            ram_we    = 1'b1;
            ram_waddr = i_reg;
            ram_wdata = cur_reg;
        end
        ram_re    = cmd.rd_rec || cmd.rd_i || cmd.rd_j;
        ram_raddr = rd_ptr_reg;
        if (cmd.rd_i)
        begin
            ram_raddr = i_reg;
        end
        else if (cmd.rd_j)
        begin
            ram_raddr = j_reg;
        end
    end

    des_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg  <= '0;
            rd_ptr_reg    <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            desc_reg      <= 1'b0;
            sort_desc_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                desc_reg <= cfg_descending;
            end
            if (cmd.load_wr)
            begin
                load_cnt_reg <= stat.load_last ? '0 : load_cnt_reg + IDX_W'(1);
            end
            if (cmd.sort_start)
            begin
                i_reg         <= '0;
                rd_ptr_reg    <= '0;
                sort_desc_reg <= desc_reg;
            end
            if (cmd.rd_i)
            begin
                j_reg <= i_reg + IDX_W'(1);
            end
            if (cmd.cmp)
            begin
                j_reg <= j_reg + IDX_W'(1);
            end
            if (cmd.wb_i)
            begin
                i_reg <= i_reg + IDX_W'(1);
            end
            if (cmd.out_rec)
            begin
                rd_ptr_reg <= stat.read_last ? '0 : rd_ptr_reg + IDX_W'(1);
                if (stat.read_last)
                begin
                    load_cnt_reg <= '0;
                end
            end
            if (cmd.out_rec || cmd.out_refuse)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // held record and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.get_i)
        begin
            cur_reg <= ram_rdata;
        end
        else if (cmd.cmp && swap)
        begin
            cur_reg <= ram_rdata;
        end
        if (cmd.out_rec)
        begin
            out_rec_reg    <= ram_rdata;
            out_slot_reg   <= SLOT_W'(rd_ptr_reg);
            out_last_reg   <= stat.read_last;
            out_status_reg <= STATUS_OK;
        end
        else if (cmd.out_refuse)
        begin
            out_rec_reg    <= '0;
            out_slot_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= STATUS_REFUSED;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_word0 = out_rec_reg[4*WORD_W-1 -: WORD_W];
    assign rsp.out_word1 = out_rec_reg[3*WORD_W-1 -: WORD_W];
    assign rsp.out_word2 = out_rec_reg[2*WORD_W-1 -: WORD_W];
    assign rsp.out_word3 = out_rec_reg[WORD_W-1 -: WORD_W];
    assign rsp.slot      = out_slot_reg;
    assign rsp.last      = out_last_reg;
    assign rsp.status    = out_status_reg;

endmodule

// ----- design/directory_entry_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directory_entry_sorter
// loads a table of directory records, exchange-sorts it, returns it in order
//
// channel  dir  transfer carries
// req      in   cmd, word0..word3
// rsp      out  out_word0..out_word3, slot, last, status
// cfg      in   descending
//
// load writes one record; read returns the next record; a read is refused unless sorted
// after the final load the sort holds record i, reads each later record j on the
// store read port, compares it and swaps it with the held one, then writes back i
// req is held off while a response waits in the output register or a read or sort runs
// reset clears counters and flags; the record store holds no reset value
// ----------------------------------------------------------------------------
module directory_entry_sorter (
    input  logic      clk,
    input  logic      rst_n,
    des_req_if.sink   req,
    des_rsp_if.source rsp,
    des_cfg_if.sink   cfg
);
    import des_pkg::*;

    des_cmd_t  cmd;
    des_stat_t stat;
    logic      in_ready;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    des_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    des_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .word0          (req.word0),
        .word1          (req.word1),
        .word2          (req.word2),
        .word3          (req.word3),
        .cfg_valid      (cfg.valid),
        .cfg_descending (cfg.descending),
        .cmd            (cmd),
        .stat           (stat),
        .rsp            (rsp)
    );

endmodule
